FILE: src/oledpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oledpp_pkg
// Shared types and constants of the OLED page packer: item layouts, command
// codes and the row-banked frame store geometry.
// ----------------------------------------------------------------------------
package oledpp_pkg;

   localparam int DISPLAY_WIDTH  = 126;
   localparam int DISPLAY_HEIGHT = 32;

   // frame address = row * ROW_BYTES + byte column
   localparam int BYTE_COL_BITS  = 4;
   localparam int ROW_BYTES      = 1 << BYTE_COL_BITS;
   localparam int ADDR_BITS      = 9;

   // one bank per row of a page, selected by row modulo eight
   localparam int PAGE_ROWS      = 8;
   localparam int BANK_SEL_BITS  = $clog2(PAGE_ROWS);
   localparam int BANK_ADDR_BITS = ADDR_BITS - BANK_SEL_BITS;
   localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;
   localparam int PIXEL_BITS     = 8;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_READ  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type        cmd;
      logic [8:0]     frame_address;
      logic [7:0]     frame_byte;
      logic [1:0]     page;
      logic [6:0]     column;
   } req_type;

   typedef struct packed {
      logic [7:0]     packed_byte;
      logic           out_of_range;
   } rsp_type;

   // access to the banked store for one item
   typedef struct packed {
      logic                      wr_en;
      logic [BANK_SEL_BITS-1:0]  wr_bank;
      logic [BANK_ADDR_BITS-1:0] wr_entry;
      logic [PIXEL_BITS-1:0]     wr_data;
      logic                      rd_en;
      logic [BANK_ADDR_BITS-1:0] rd_entry;
   } mem_req_type;

endpackage

FILE: src/oledpp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oledpp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module oledpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/oledpp_frame_banks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oledpp_frame_banks
// Frame store split into eight row banks; one read gathers the same byte
// column from all eight rows of a page.
// ----------------------------------------------------------------------------
module oledpp_frame_banks (
   input  logic                                                clock,
   input  oledpp_pkg::mem_req_type                             mem_req,
   output logic [oledpp_pkg::PAGE_ROWS-1:0][oledpp_pkg::PIXEL_BITS-1:0] row_data
);

   for (genvar b = 0; b < oledpp_pkg::PAGE_ROWS; b++) begin : g_bank
      logic bank_wr_en;

      assign bank_wr_en = mem_req.wr_en &&
                          (mem_req.wr_bank == oledpp_pkg::BANK_SEL_BITS'(b));

      oledpp_ram #(
         .WIDTH (oledpp_pkg::PIXEL_BITS),
         .DEPTH (oledpp_pkg::BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_wr_en),
         .wr_addr (mem_req.wr_entry),
         .wr_data (mem_req.wr_data),
         .rd_en   (mem_req.rd_en),
         .rd_addr (mem_req.rd_entry),
         .rd_data (row_data[b])
      );
   end

endmodule

FILE: src/oled_page_packer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oled_page_packer_core
// Stores a 1-bit frame row-major and returns display page bytes: bit k of a
// result is the pixel at the requested column in row page*8+k.
// ----------------------------------------------------------------------------
//  channel   ports                        direction  handshake
//  request   start, busy, req_data        in         start && !busy
//  response  rsp_valid, rsp_data          out        rsp_valid, one cycle
//
//  One item per cycle, every cycle; busy is always low. A write item
//  produces nothing; a read item gives its result after the bank RAM
//  read register and then the output register. Each of the eight row
//  banks has its own RAM port, so a whole page column comes out in one read.
//  Reset clears only the read and response strobes; frame contents are
//  undefined until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module oled_page_packer_core #(
   parameter int DISPLAY_WIDTH  = oledpp_pkg::DISPLAY_WIDTH,
   parameter int DISPLAY_HEIGHT = oledpp_pkg::DISPLAY_HEIGHT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  oledpp_pkg::req_type req_data,
   output logic                rsp_valid,
   output oledpp_pkg::rsp_type rsp_data
);

   localparam int BC = oledpp_pkg::BYTE_COL_BITS;
   localparam int BS = oledpp_pkg::BANK_SEL_BITS;

   logic                    accept;
   oledpp_pkg::mem_req_type mem_req;
   logic [oledpp_pkg::PAGE_ROWS-1:0][oledpp_pkg::PIXEL_BITS-1:0] row_data;

   logic       rd_valid_ff, rd_valid_in;
   logic [2:0] bit_sel_ff, bit_sel_in;
   logic [1:0] page_ff, page_in;
   logic       oor_ff, oor_in;

   logic                rsp_valid_ff;
   oledpp_pkg::rsp_type rsp_ff, rsp_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      mem_req.wr_en    = accept && (req_data.cmd == oledpp_pkg::CMD_WRITE);
      mem_req.wr_bank  = req_data.frame_address[BC+BS-1:BC];
      mem_req.wr_entry = {req_data.frame_address[oledpp_pkg::ADDR_BITS-1:BC+BS],
                          req_data.frame_address[BC-1:0]};
      mem_req.wr_data  = req_data.frame_byte;
      mem_req.rd_en    = accept && (req_data.cmd == oledpp_pkg::CMD_READ);
      // every row of the page sits at the same entry of its own bank
      mem_req.rd_entry = {req_data.page, req_data.column[6:3]};
   end

   oledpp_frame_banks u_banks (
      .clock    (clock),
      .mem_req  (mem_req),
      .row_data (row_data)
   );

   assign rd_valid_in = mem_req.rd_en;
   assign bit_sel_in  = ~req_data.column[2:0];
   assign page_in     = req_data.page;
   assign oor_in      = {1'b0, req_data.column} >= 8'(DISPLAY_WIDTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_sel_ff <= bit_sel_in;
      page_ff    <= page_in;
      oor_ff     <= oor_in;
   end

   // pick the column's pixel out of each row byte; drop rows below the frame
   always_comb begin
      logic [7:0] row;
      rsp_in = '0;
      for (int k = 0; k < oledpp_pkg::PAGE_ROWS; k++) begin
         row = {3'b000, page_ff, 3'(k)};
         if (!oor_ff && (row < 8'(DISPLAY_HEIGHT))) begin
            rsp_in.packed_byte[k] = row_data[k][bit_sel_ff];
         end
      end
      rsp_in.out_of_range = oor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for oled_page_packer_core. A short table of directed
// items hits the column and page extremes, the out-of-range columns and the
// ignored fields. Random items follow: mostly fills of one page byte column
// followed by reads of it, mixed with single reads and stray writes. A mirror
// of the frame predicts every page byte; each response is compared field by
// field with the oldest prediction. The sender runs in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_top;
   import oledpp_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_PRINTS   = 40;
   localparam int STORE_DEPTH  = 1 << ADDR_BITS;

   typedef struct packed {
      req_type  req;
      logic     typed;
      rsp_type  rsp;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic [PIXEL_BITS-1:0] frame_img [STORE_DEPTH];
   bit                    frame_written [STORE_DEPTH];
   rsp_type               pending_rsp [$];
   int                    err_count = 0;
   int                    cycle_count = 0;
   int                    burst_left = 0;

   // columns 0 and 7 come from the first byte column, 120 and 125 from the last
   dir_row_type directed_rows [0:21] = '{
      '{'{CMD_READ,  9'd511, 8'hFF, 2'd0, 7'd126}, 1'b1, '{8'h00, 1'b1}},
      '{'{CMD_READ,  9'd0,   8'h00, 2'd3, 7'd127}, 1'b1, '{8'h00, 1'b1}},
      '{'{CMD_WRITE, 9'd0,   8'h80, 2'd3, 7'd127}, 1'b0, '0},
      '{'{CMD_WRITE, 9'd16,  8'h00, 2'd0, 7'd0},   1'b0, '0},
      '{'{CMD_WRITE, 9'd32,  8'hFF, 2'd1, 7'd64},  1'b0, '0},
      '{'{CMD_WRITE, 9'd48,  8'h7F, 2'd2, 7'd1},   1'b0, '0},
      '{'{CMD_WRITE, 9'd64,  8'hC3, 2'd3, 7'd126}, 1'b0, '0},
      '{'{CMD_WRITE, 9'd80,  8'h01, 2'd0, 7'd5},   1'b0, '0},
      '{'{CMD_WRITE, 9'd96,  8'hFE, 2'd1, 7'd33},  1'b0, '0},
      '{'{CMD_WRITE, 9'd112, 8'h80, 2'd2, 7'd99},  1'b0, '0},
      '{'{CMD_READ,  9'd511, 8'hFF, 2'd0, 7'd0},   1'b0, '0},
      '{'{CMD_READ,  9'd0,   8'h00, 2'd0, 7'd7},   1'b0, '0},
      '{'{CMD_WRITE, 9'd399, 8'hFF, 2'd0, 7'd0},   1'b0, '0},
      '{'{CMD_WRITE, 9'd415, 8'h00, 2'd1, 7'd1},   1'b0, '0},
      '{'{CMD_WRITE, 9'd431, 8'hAA, 2'd2, 7'd2},   1'b0, '0},
      '{'{CMD_WRITE, 9'd447, 8'h55, 2'd3, 7'd3},   1'b0, '0},
      '{'{CMD_WRITE, 9'd463, 8'h04, 2'd0, 7'd127}, 1'b0, '0},
      '{'{CMD_WRITE, 9'd479, 8'hFB, 2'd1, 7'd125}, 1'b0, '0},
      '{'{CMD_WRITE, 9'd495, 8'hFF, 2'd2, 7'd64},  1'b0, '0},
      '{'{CMD_WRITE, 9'd511, 8'h00, 2'd3, 7'd32},  1'b0, '0},
      '{'{CMD_READ,  9'd255, 8'h5A, 2'd3, 7'd125}, 1'b0, '0},
      '{'{CMD_READ,  9'd256, 8'hA5, 2'd3, 7'd120}, 1'b0, '0}
   };

   oled_page_packer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [ADDR_BITS-1:0] pixel_addr(input int row, input int col);
      return ADDR_BITS'(row * ROW_BYTES + col / PIXEL_BITS);
   endfunction

   // gather bit k from row page*8+k at the given column
   function automatic rsp_type pack_page_column(input logic [1:0] pg, input logic [6:0] col);
      rsp_type          r;
      int               row;
      int               k;
      logic [ADDR_BITS-1:0] addr;
      r = '0;
      if (int'(col) >= DISPLAY_WIDTH) begin
         r.out_of_range = 1'b1;
         return r;
      end
      for (k = 0; k < PAGE_ROWS; k++) begin
         row = int'(pg) * PAGE_ROWS + k;
         if (row < DISPLAY_HEIGHT) begin
            addr = pixel_addr(row, int'(col));
            r.packed_byte[k] = frame_img[addr][PIXEL_BITS - 1 - int'(col) % PIXEL_BITS];
         end
      end
      return r;
   endfunction

   // true when a read at this page and column touches only written bytes
   function automatic bit column_ready(input logic [1:0] pg, input logic [6:0] col);
      int k;
      if (int'(col) >= DISPLAY_WIDTH)
         return 1'b1;
      for (k = 0; k < PAGE_ROWS; k++)
         if (!frame_written[pixel_addr(int'(pg) * PAGE_ROWS + k, int'(col))])
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic req_type make_write(input logic [8:0] addr, input logic [7:0] data);
      req_type r;
      r.cmd           = CMD_WRITE;
      r.frame_address = addr;
      r.frame_byte    = data;
      r.page          = 2'($urandom);
      r.column        = 7'($urandom);
      return r;
   endfunction

   function automatic req_type make_read(input logic [1:0] pg, input logic [6:0] col);
      req_type r;
      r.cmd           = CMD_READ;
      r.frame_address = 9'($urandom);
      r.frame_byte    = 8'($urandom);
      r.page          = pg;
      r.column        = col;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (err_count < MAX_PRINTS)
         $display("MISMATCH at %0t ns: %s", $time, what);
      err_count++;
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         req_data <= req_type'(27'($urandom));
         repeat (n) @(posedge clock);
      end
   endtask

   // hold the item until it is taken, then update the frame mirror or
   // queue the page byte it will return
   task automatic issue_item(input req_type item, input logic typed, input rsp_type exp_rsp);
      if (burst_left == 0) begin
         idle_cycles($urandom_range(0, 6));
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 16);
      end
      burst_left--;
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      if (item.cmd == CMD_WRITE) begin
         frame_img[item.frame_address] = item.frame_byte;
         frame_written[item.frame_address] = 1'b1;
      end else begin
         pending_rsp.push_back(typed ? exp_rsp : pack_page_column(item.page, item.column));
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("response with nothing expected, byte %02h oor %b",
                                      rsp_data.packed_byte, rsp_data.out_of_range));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.packed_byte !== want.packed_byte)
               report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                         rsp_data.packed_byte, want.packed_byte));
            if (rsp_data.out_of_range !== want.out_of_range)
               report_mismatch($sformatf("out_of_range %b, expected %b",
                                         rsp_data.out_of_range, want.out_of_range));
         end
      end
   end

   initial begin
      int          rand_sent;
      int          pick;
      int          k;
      int          j;
      int          nreads;
      logic [1:0]  pg;
      logic [3:0]  bc;
      logic [6:0]  col;

      rand_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      while (rand_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 4) begin
            // fill one byte column of a page, then read columns out of it
            pg = 2'($urandom);
            bc = 4'($urandom);
            for (k = 0; k < PAGE_ROWS; k++)
               issue_item(make_write(pixel_addr(int'(pg) * PAGE_ROWS + k,
                                                int'(bc) * PIXEL_BITS), 8'($urandom)),
                          1'b0, '0);
            nreads = $urandom_range(1, 4);
            for (j = 0; j < nreads; j++)
               issue_item(make_read(pg, 7'(int'(bc) * PIXEL_BITS + $urandom_range(0, 7))),
                          1'b0, '0);
            rand_sent += PAGE_ROWS + nreads;
         end else if (pick <= 7) begin
            pg  = 2'($urandom);
            col = 7'($urandom);
            // redirect reads of unfilled columns past the display edge
            if (!column_ready(pg, col))
               col = 7'(DISPLAY_WIDTH + $urandom_range(0, 1));
            issue_item(make_read(pg, col), 1'b0, '0);
            rand_sent++;
         end else begin
            issue_item(make_write(9'($urandom), 8'($urandom)), 1'b0, '0);
            rand_sent++;
         end
      end

      idle_cycles(1);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
